// ===== hw/rtl/bptc_pkg.sv =====
// Shared types, register indexes and arithmetic constants of the barometer compensation block.
package bptc_pkg;

    // Configuration register indexes (byte address is 8 times the index).
    localparam logic [1:0] REG_TEMP_CAL    = 2'd0;
    localparam logic [1:0] REG_PRESS_CAL_A = 2'd1;
    localparam logic [1:0] REG_PRESS_CAL_B = 2'd2;
    localparam logic [1:0] REG_PRESS_CAL_C = 2'd3;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    // Arithmetic constants of the compensation formulas.
    localparam logic [32:0] FINE_OFFSET   = 33'd128000;
    localparam logic [11:0] PRESS_SCALE   = 12'd3125;
    localparam logic [20:0] PRESS_BASE    = 21'd1048576;
    localparam int          P1_BIAS_SHIFT = 47;
    localparam int          P1_PROD_SHIFT = 33;
    localparam int          P4_SHIFT      = 35;
    localparam logic [63:0] P1_BIAS       = 64'd1 << P1_BIAS_SHIFT;

    // Quotient bits resolved by the divider, one per stage.
    localparam int DIV_STAGES = 64;

    // Unpacked calibration coefficients.
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } cal_t;

    // Temperature results that ride along with the pressure path.
    typedef struct packed {
        logic signed [31:0] fine;
        logic signed [31:0] tc;
    } temp_t;

    // Sideband that travels through the divider.
    typedef struct packed {
        temp_t temp;
        logic  invalid;
        logic  neg;
    } side_t;

    // One finished result.
    typedef struct packed {
        temp_t       temp;
        logic [31:0] press;
        logic        invalid;
    } res_t;

endpackage

// ===== hw/rtl/bptc_sample_if.sv =====
// Input channel carrying one raw temperature and pressure sample pair.
interface bptc_sample_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

// ===== hw/rtl/bptc_result_if.sv =====
// Output channel carrying one compensated temperature and pressure result.
interface bptc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centi;
    logic        [31:0] pressure_q24_8;
    logic               pressure_invalid;

    modport source (output valid, output fine_temperature, output temperature_centi,
                    output pressure_q24_8, output pressure_invalid, input ready);
    modport sink (input valid, input fine_temperature, input temperature_centi,
                  input pressure_q24_8, input pressure_invalid, output ready);
endinterface

// ===== hw/rtl/bptc_cfg.sv =====
// APB calibration register file with coefficient unpacking.
module bptc_cfg
    import bptc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output cal_t                  cal
);
    logic [47:0] temp_cal_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [15:0] press_c_reg;
    logic        wr_en;
    logic [1:0]  reg_index;

    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[4:3];

    // Register writes on the access phase of a write transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg <= '0;
            press_a_reg  <= '0;
            press_b_reg  <= '0;
            press_c_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_TEMP_CAL:    temp_cal_reg <= pwdata[47:0];
                REG_PRESS_CAL_A: press_a_reg  <= pwdata;
                REG_PRESS_CAL_B: press_b_reg  <= pwdata;
                REG_PRESS_CAL_C: press_c_reg  <= pwdata[15:0];
                default:         press_c_reg  <= press_c_reg;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (reg_index)
            REG_TEMP_CAL:    prdata = {16'd0, temp_cal_reg};
            REG_PRESS_CAL_A: prdata = press_a_reg;
            REG_PRESS_CAL_B: prdata = press_b_reg;
            REG_PRESS_CAL_C: prdata = {48'd0, press_c_reg};
            default:         prdata = '0;
        endcase
    end

    // Split the packed words into coefficients.
    assign cal.t1 = temp_cal_reg[15:0];
    assign cal.t2 = temp_cal_reg[31:16];
    assign cal.t3 = temp_cal_reg[47:32];
    assign cal.p1 = press_a_reg[15:0];
    assign cal.p2 = press_a_reg[31:16];
    assign cal.p3 = press_a_reg[47:32];
    assign cal.p4 = press_a_reg[63:48];
    assign cal.p5 = press_b_reg[15:0];
    assign cal.p6 = press_b_reg[31:16];
    assign cal.p7 = press_b_reg[47:32];
    assign cal.p8 = press_b_reg[63:48];
    assign cal.p9 = press_c_reg;

endmodule

// ===== hw/rtl/bptc_front.sv =====
// Temperature pipeline and pressure dividend and divisor preparation, twelve stages.
module bptc_front
    import bptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ce,
    input  logic        in_valid,
    input  logic [19:0] raw_temperature,
    input  logic [19:0] raw_pressure,
    input  cal_t        cal,
    output logic        out_valid,
    output logic [63:0] num_mag,
    output logic [30:0] den_mag,
    output side_t       side
);
    localparam int STAGES = 12;

    logic [STAGES-1:0]  valid_reg;

    logic signed [17:0] x1_reg;
    logic signed [16:0] d_reg;
    logic        [20:0] pn_pipe_reg [1:8];
    logic signed [31:0] v1_reg;
    logic signed [19:0] dds_reg;
    logic signed [31:0] v1_d_reg;
    logic signed [17:0] v2_reg;
    logic signed [31:0] fine_reg;
    temp_t              temp_pipe_reg [5:11];
    logic signed [32:0] a_reg;
    logic        [63:0] aa_reg;
    logic signed [48:0] ap5_reg;
    logic signed [48:0] ap2_reg;
    logic signed [48:0] pp6l_reg;
    logic        [31:0] pp6h_reg;
    logic signed [48:0] pp3l_reg;
    logic        [31:0] pp3h_reg;
    logic        [63:0] c5_reg;
    logic signed [48:0] ap2_d_reg;
    logic        [63:0] b_reg;
    logic        [63:0] a3_reg;
    logic signed [48:0] ap2_dd_reg;
    logic        [63:0] nb_reg;
    logic        [63:0] s_reg;
    logic        [43:0] nl_reg;
    logic        [31:0] nh_reg;
    logic        [47:0] sl_reg;
    logic        [31:0] sh_reg;
    logic        [63:0] n_reg;
    logic        [30:0] dv_reg;
    logic        [63:0] num_reg;
    logic        [30:0] den_reg;
    side_t              side_reg;

    logic signed [17:0] x1_next;
    logic signed [16:0] d_next;
    logic        [20:0] pn_next;
    logic signed [33:0] m1;
    logic signed [33:0] sq;
    logic signed [35:0] m2;
    logic        [31:0] tc_sum;
    logic        [31:0] tc_next;
    logic signed [32:0] a_next;
    logic signed [65:0] aa_full;
    logic signed [48:0] ap5_full;
    logic signed [48:0] ap2_full;
    logic signed [48:0] pp6l_full;
    logic signed [47:0] pp6h_full;
    logic signed [48:0] pp3l_full;
    logic signed [47:0] pp3h_full;
    logic        [63:0] c5_next;
    logic        [63:0] b_next;
    logic        [63:0] a3_next;
    logic        [63:0] nb_next;
    logic        [63:0] s_next;
    logic        [43:0] nl_full;
    logic        [43:0] nh_full;
    logic        [47:0] sl_full;
    logic        [47:0] sh_full;
    logic        [63:0] n_next;
    logic        [63:0] sum_a;

    // Stage 1: offsets against T1 and the pressure base.
    assign x1_next = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    assign d_next  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
    assign pn_next = PRESS_BASE - {1'b0, raw_pressure};

    // Stages 2 and 3: the two temperature products, each wrapped to 32 bits.
    assign m1 = x1_reg * $signed(cal.t2);
    assign sq = d_reg * d_reg;
    assign m2 = dds_reg * $signed(cal.t3);

    // Stage 5: centidegrees and the centered fine temperature.
    assign tc_sum  = {fine_reg[29:0], 2'b00} + fine_reg + 32'd128;
    assign tc_next = {{8{tc_sum[31]}}, tc_sum[31:8]};
    assign a_next  = $signed({fine_reg[31], fine_reg}) - $signed(FINE_OFFSET);

    // Stage 6: square and first-order products of the centered temperature.
    assign aa_full  = a_reg * a_reg;
    assign ap5_full = a_reg * $signed(cal.p5);
    assign ap2_full = a_reg * $signed(cal.p2);

    // Stage 7: 64 by 16 products split into low and high 32-bit halves.
    assign pp6l_full = $signed({1'b0, aa_reg[31:0]}) * $signed(cal.p6);
    assign pp6h_full = $signed(aa_reg[63:32]) * $signed(cal.p6);
    assign pp3l_full = $signed({1'b0, aa_reg[31:0]}) * $signed(cal.p3);
    assign pp3h_full = $signed(aa_reg[63:32]) * $signed(cal.p3);
    assign c5_next   = ({{15{ap5_reg[48]}}, ap5_reg} << 17)
                     + ({{48{cal.p4[15]}}, cal.p4} << P4_SHIFT);

    // Stage 8: recombine the halves.
    assign b_next  = {{15{pp6l_reg[48]}}, pp6l_reg} + {pp6h_reg, 32'd0} + c5_reg;
    assign a3_next = {{15{pp3l_reg[48]}}, pp3l_reg} + {pp3h_reg, 32'd0};

    // Stage 9: dividend before scaling and the biased divisor term.
    assign nb_next = {12'd0, pn_pipe_reg[8], 31'd0} - b_reg;
    assign s_next  = {{8{a3_reg[63]}}, a3_reg[63:8]}
                   + ({{15{ap2_dd_reg[48]}}, ap2_dd_reg} << 12) + P1_BIAS;

    // Stage 10: scale and P1 products in halves.
    assign nl_full = nb_reg[31:0] * PRESS_SCALE;
    assign nh_full = nb_reg[63:32] * PRESS_SCALE;
    assign sl_full = s_reg[31:0] * cal.p1;
    assign sh_full = s_reg[63:32] * cal.p1;

    // Stage 11: final dividend and divisor.
    assign n_next = {20'd0, nl_reg} + {nh_reg, 32'd0};
    assign sum_a  = {16'd0, sl_reg} + {sh_reg, 32'd0};

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ce)
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x1_reg         <= x1_next;
            d_reg          <= d_next;
            pn_pipe_reg[1] <= pn_next;
            for (int i = 2; i <= 8; i++)
                pn_pipe_reg[i] <= pn_pipe_reg[i-1];

            v1_reg  <= $signed(m1[31:0]) >>> 11;
            dds_reg <= sq[31:12];

            v1_d_reg <= v1_reg;
            v2_reg   <= m2[31:14];

            fine_reg <= v1_d_reg + {{14{v2_reg[17]}}, v2_reg};

            temp_pipe_reg[5] <= '{fine: fine_reg, tc: tc_next};
            for (int i = 6; i <= 11; i++)
                temp_pipe_reg[i] <= temp_pipe_reg[i-1];
            a_reg <= a_next;

            aa_reg  <= aa_full[63:0];
            ap5_reg <= ap5_full;
            ap2_reg <= ap2_full;

            pp6l_reg  <= pp6l_full;
            pp6h_reg  <= pp6h_full[31:0];
            pp3l_reg  <= pp3l_full;
            pp3h_reg  <= pp3h_full[31:0];
            c5_reg    <= c5_next;
            ap2_d_reg <= ap2_reg;

            b_reg      <= b_next;
            a3_reg     <= a3_next;
            ap2_dd_reg <= ap2_d_reg;

            nb_reg <= nb_next;
            s_reg  <= s_next;

            nl_reg <= nl_full;
            nh_reg <= nh_full[31:0];
            sl_reg <= sl_full;
            sh_reg <= sh_full[31:0];

            n_reg  <= n_next;
            dv_reg <= sum_a[63:P1_PROD_SHIFT];

            // Stage 12: magnitudes and the quotient sign for the divider.
            num_reg          <= n_reg[63] ? (64'd0 - n_reg) : n_reg;
            den_reg          <= dv_reg[30] ? (31'd0 - dv_reg) : dv_reg;
            side_reg.temp    <= temp_pipe_reg[11];
            side_reg.invalid <= (dv_reg == 31'd0);
            side_reg.neg     <= n_reg[63] ^ dv_reg[30];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign num_mag   = num_reg;
    assign den_mag   = den_reg;
    assign side      = side_reg;

endmodule

// ===== hw/rtl/bptc_div.sv =====
// Pipelined restoring divider of a 64-bit magnitude by a 31-bit magnitude, one bit per stage.
module bptc_div
    import bptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ce,
    input  logic        in_valid,
    input  logic [63:0] num_mag,
    input  logic [30:0] den_mag,
    input  side_t       side_in,
    output logic        out_valid,
    output logic [63:0] quot_mag,
    output side_t       side_out
);
    logic [DIV_STAGES:1] valid_reg;
    logic [30:0]         rem_reg  [1:DIV_STAGES-1];
    logic [30:0]         den_reg  [1:DIV_STAGES-1];
    logic [63:0]         nq_reg   [1:DIV_STAGES];
    side_t               side_reg [1:DIV_STAGES];

    logic [30:0]         rem_cur  [0:DIV_STAGES-1];
    logic [30:0]         den_cur  [0:DIV_STAGES-1];
    logic [63:0]         nq_cur   [0:DIV_STAGES-1];
    logic [30:0]         shifted  [0:DIV_STAGES-1];
    logic [31:0]         diff     [0:DIV_STAGES-1];

    // Trial subtraction in every stage; the dividend shifts out as quotient bits shift in.
    always_comb
    begin
        rem_cur[0] = '0;
        den_cur[0] = den_mag;
        nq_cur[0]  = num_mag;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            rem_cur[k] = rem_reg[k];
            den_cur[k] = den_reg[k];
            nq_cur[k]  = nq_reg[k];
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            shifted[k] = {rem_cur[k][29:0], nq_cur[k][63]};
            diff[k]    = {1'b0, shifted[k]} - {1'b0, den_cur[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ce)
            valid_reg <= {valid_reg[DIV_STAGES-1:1], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < DIV_STAGES - 1; k++)
            begin
                rem_reg[k+1] <= diff[k][31] ? shifted[k] : diff[k][30:0];
                den_reg[k+1] <= den_cur[k];
            end
            for (int k = 0; k < DIV_STAGES; k++)
                nq_reg[k+1] <= {nq_cur[k][62:0], ~diff[k][31]};
            side_reg[1] <= side_in;
            for (int k = 2; k <= DIV_STAGES; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES];
    assign quot_mag  = nq_reg[DIV_STAGES];
    assign side_out  = side_reg[DIV_STAGES];

endmodule

// ===== hw/rtl/bptc_back.sv =====
// Second-order pressure correction after the divide, seven stages.
module bptc_back
    import bptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ce,
    input  logic        in_valid,
    input  logic [63:0] quot_mag,
    input  side_t       side_in,
    input  cal_t        cal,
    output logic        out_valid,
    output res_t        res
);
    localparam int STAGES = 7;

    logic [STAGES-1:0]  valid_reg;
    side_t              side_pipe_reg [1:6];
    logic        [63:0] p_reg;
    logic        [63:0] sq_reg;
    logic        [31:0] cross_reg;
    logic signed [48:0] pp8l_reg;
    logic        [31:0] pp8h_reg;
    logic        [39:0] p2_reg;
    logic        [63:0] qq_reg;
    logic        [39:0] w2_reg;
    logic        [39:0] p3_reg;
    logic signed [48:0] qql_reg;
    logic        [31:0] qqh_reg;
    logic        [39:0] w2_d_reg;
    logic        [39:0] p4_reg;
    logic        [39:0] w1_reg;
    logic        [39:0] w2_dd_reg;
    logic        [39:0] p5_reg;
    logic        [39:0] s_reg;
    res_t               res_reg;

    logic        [63:0] q;
    logic        [63:0] cross_full;
    logic signed [48:0] pp8l_full;
    logic signed [47:0] pp8h_full;
    logic        [63:0] w2_sum;
    logic signed [48:0] qql_full;
    logic signed [47:0] qqh_full;
    logic        [63:0] w1_sum;
    logic        [31:0] press_sum;

    // Stage 2: q = p >> 13; square and P8 products in 32-bit halves.
    assign q          = {{13{p_reg[63]}}, p_reg[63:13]};
    assign cross_full = q[31:0] * q[63:32];
    assign pp8l_full  = $signed({1'b0, p_reg[31:0]}) * $signed(cal.p8);
    assign pp8h_full  = $signed(p_reg[63:32]) * $signed(cal.p8);

    // Stage 3: recombine; only the low 40 bits of later terms reach the result.
    assign w2_sum = {{15{pp8l_reg[48]}}, pp8l_reg} + {pp8h_reg, 32'd0};

    // Stage 4: P9 products of the wrapped square.
    assign qql_full = $signed({1'b0, qq_reg[31:0]}) * $signed(cal.p9);
    assign qqh_full = $signed(qq_reg[63:32]) * $signed(cal.p9);

    // Stage 5 recombines; stage 7 applies the P7 offset on the shifted sum.
    assign w1_sum    = {{15{qql_reg[48]}}, qql_reg} + {qqh_reg, 32'd0};
    assign press_sum = s_reg[39:8] + {{12{cal.p7[15]}}, cal.p7, 4'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (ce)
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side_pipe_reg[1] <= side_in;
            for (int i = 2; i <= 6; i++)
                side_pipe_reg[i] <= side_pipe_reg[i-1];

            p_reg <= side_in.neg ? (64'd0 - quot_mag) : quot_mag;

            sq_reg    <= q[31:0] * q[31:0];
            cross_reg <= cross_full[31:0];
            pp8l_reg  <= pp8l_full;
            pp8h_reg  <= pp8h_full[31:0];
            p2_reg    <= p_reg[39:0];

            qq_reg <= sq_reg + {cross_reg[30:0], 33'd0};
            w2_reg <= w2_sum[58:19];
            p3_reg <= p2_reg;

            qql_reg  <= qql_full;
            qqh_reg  <= qqh_full[31:0];
            w2_d_reg <= w2_reg;
            p4_reg   <= p3_reg;

            w1_reg    <= {w1_sum[63], w1_sum[63:25]};
            w2_dd_reg <= w2_d_reg;
            p5_reg    <= p4_reg;

            s_reg <= p5_reg + w1_reg + w2_dd_reg;

            res_reg.temp    <= side_pipe_reg[6].temp;
            res_reg.invalid <= side_pipe_reg[6].invalid;
            res_reg.press   <= side_pipe_reg[6].invalid ? 32'd0 : press_sum;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign res       = res_reg;

endmodule

// ===== hw/rtl/barometer_temp_pressure_compensation.sv =====
// Top level of the barometer temperature and pressure compensation pipeline.
//
// One raw sample pair is accepted per clock while ready is high, giving one result
// after temperature and operand preparation, the 64-stage bit-per-stage divider,
// second-order correction and one output register. Throughput is one item per cycle
// while ready is high. The output register plus a one-entry skid register let the
// pipeline keep taking samples while a result waits; ready drops only when both hold
// a result. Calibration registers sit on the APB port at byte addresses 0, 8, 16 and
// 24; the user is to write them only while the block is idle, and the block does not
// enforce this. A zero divisor gives a pressure of 0 with pressure_invalid set.
module barometer_temp_pressure_compensation
    import bptc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    bptc_sample_if.sink           sample,
    bptc_result_if.source         result
);
    cal_t        cal;
    logic        ce;
    logic        front_valid;
    logic [63:0] num_mag;
    logic [30:0] den_mag;
    side_t       front_side;
    logic        div_valid;
    logic [63:0] quot_mag;
    side_t       div_side;
    logic        back_valid;
    res_t        back_res;
    logic        arrive;
    logic        out_take;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    res_t        out_data_reg;
    res_t        skid_data_reg;

    assign pready = 1'b1;

    // The pipeline advances unless the skid register holds a result.
    assign ce           = ~skid_valid_reg;
    assign sample.ready = ce;

    bptc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cal     (cal)
    );

    bptc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .ce              (ce),
        .in_valid        (sample.valid),
        .raw_temperature (sample.raw_temperature),
        .raw_pressure    (sample.raw_pressure),
        .cal             (cal),
        .out_valid       (front_valid),
        .num_mag         (num_mag),
        .den_mag         (den_mag),
        .side            (front_side)
    );

    bptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (front_valid),
        .num_mag   (num_mag),
        .den_mag   (den_mag),
        .side_in   (front_side),
        .out_valid (div_valid),
        .quot_mag  (quot_mag),
        .side_out  (div_side)
    );

    bptc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (div_valid),
        .quot_mag  (quot_mag),
        .side_in   (div_side),
        .cal       (cal),
        .out_valid (back_valid),
        .res       (back_res)
    );

    // Output register with skid entry.
    assign arrive   = back_valid & ce;
    assign out_take = ~out_valid_reg | result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg  <= skid_valid_reg | arrive;
            skid_valid_reg <= 1'b0;
        end
        else if (arrive)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
            out_data_reg <= skid_valid_reg ? skid_data_reg : back_res;
        else if (arrive)
            skid_data_reg <= back_res;
    end

    assign result.valid             = out_valid_reg;
    assign result.fine_temperature  = out_data_reg.temp.fine;
    assign result.temperature_centi = out_data_reg.temp.tc;
    assign result.pressure_q24_8    = out_data_reg.press;
    assign result.pressure_invalid  = out_data_reg.invalid;

    // The skid entry only fills behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // The skid entry fills only when a result was stalled at the output.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(result.valid && !result.ready))
        else $error("skid entry filled without an output stall");

    // A zero divisor always reports a zero pressure.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.pressure_invalid) |-> (result.pressure_q24_8 == 32'd0))
        else $error("invalid pressure result is not zero");

endmodule
